>>> sv/bridge_frame_crc_checker_assert.svh
// Assertion macros shared by the frame checker modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BRIDGE_FRAME_CRC_CHECKER_ASSERT_SVH
`define BRIDGE_FRAME_CRC_CHECKER_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define BCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bcc_pkg.sv
// Types, codes and the CRC-16/CCITT byte step for the bridge frame checker.
// No dependencies; used by the front end, back end, top level and testbench.
package bcc_pkg;

  localparam int unsigned POS_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  MAGIC_RST = 8'hB8;
  localparam logic [7:0]  TYPE_RST  = 8'h31;
  localparam logic [7:0]  VER_RST   = 8'h01;
  localparam logic [7:0]  KEY_RST   = 8'hFF;

  // Fixed frame layout ahead of the report bytes.
  localparam logic [POS_W-1:0] POS_MAGIC = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
  localparam logic [POS_W-1:0] POS_VER   = 4'd2;
  localparam logic [POS_W-1:0] POS_SEQ   = 4'd3;
  localparam logic [POS_W-1:0] POS_FLAGS = 4'd4;
  localparam logic [POS_W-1:0] POS_RPT   = 4'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd2;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_HDR_BAD = 2'd1,
    ST_CRC_BAD = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    status_t     frame_status;
    logic [63:0] held_report;
    logic [7:0]  held_sequence;
    logic [7:0]  held_flags;
    logic [7:0]  held_first_key;
    logic [31:0] good_frames;
    logic [31:0] crc_failures;
    logic [31:0] header_failures;
  } out_t;

  // Classified frame handed from the front end to the back end.
  typedef struct packed {
    logic        hdr_ok;
    logic        crc_ok;
    logic [63:0] report;
    logic [7:0]  sequence_b;
    logic [7:0]  flags;
    logic [7:0]  lead_key;
  } rec_t;

  // One byte of CRC-16/CCITT, MSB first, no reflection.
  function automatic logic [15:0] crc8_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> sv/bcc_fifo.sv
// Small register queue with push/full and pop/empty handshakes.
// Generic in width and depth; no package dependency.
module bcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> sv/bcc_front.sv
// Front end: takes frame bytes, tracks position, runs the CRC, checks the
// header and stages the payload fields. Depends on bcc_pkg and the assert header.
`include "bridge_frame_crc_checker_assert.svh"

module bcc_front #(
  parameter int unsigned REPORT_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_push,
  input  bcc_pkg::in_t                  in_data,
  output logic                          in_full,
  output logic                          rec_push,
  output bcc_pkg::rec_t                 rec,
  input  logic                          rec_full
);

  localparam logic [bcc_pkg::POS_W-1:0] KeyPos   = bcc_pkg::POS_W'(5 + REPORT_BYTES);
  localparam logic [bcc_pkg::POS_W-1:0] CrcLoPos = bcc_pkg::POS_W'(6 + REPORT_BYTES);
  localparam logic [bcc_pkg::POS_W-1:0] LastPos  = bcc_pkg::POS_W'(7 + REPORT_BYTES);

  logic [7:0]                magic_r, type_r, ver_r;
  logic [bcc_pkg::POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [15:0]               crc_r, crc_nxt, crc_base;
  logic                      hdr_r, hdr_nxt, hdr_base;
  logic [63:0]               rpt_r, rpt_nxt;
  logic [7:0]                seq_r, seq_nxt;
  logic [7:0]                flags_r, flags_nxt;
  logic [7:0]                key_r, key_nxt;
  logic [7:0]                crc_lo_r, crc_lo_nxt;
  logic [bcc_pkg::POS_W-1:0] rpt_off;
  logic [2:0]                rpt_idx;
  logic                      accept;
  logic [7:0]                b;
  logic                      start_take, magic_miss;

  assign b       = in_data.data_byte;
  assign in_full = rec_full;
  assign accept  = in_push && !rec_full;
  assign pos_eff = (in_data.frame_start || pos_r > LastPos) ? '0 : pos_r;
  assign rpt_off = pos_eff - bcc_pkg::POS_RPT;
  assign rpt_idx = rpt_off[2:0];

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= bcc_pkg::MAGIC_RST;
      type_r  <= bcc_pkg::TYPE_RST;
      ver_r   <= bcc_pkg::VER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bcc_pkg::CFG_MAGIC:   magic_r <= cfg_data;
        bcc_pkg::CFG_TYPE:    type_r  <= cfg_data;
        bcc_pkg::CFG_VERSION: ver_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-byte update of position, CRC, header flag and staged fields.
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    rpt_nxt    = rpt_r;
    seq_nxt    = seq_r;
    flags_nxt  = flags_r;
    key_nxt    = key_r;
    crc_lo_nxt = crc_lo_r;
    crc_base   = (pos_eff == '0) ? bcc_pkg::CRC_INIT : crc_r;
    hdr_base   = (pos_eff == '0) ? 1'b1 : hdr_r;
    if (accept) begin
      hdr_nxt = hdr_base;
      if (pos_eff == bcc_pkg::POS_MAGIC && b != magic_r) hdr_nxt = 1'b0;
      if (pos_eff == bcc_pkg::POS_TYPE  && b != type_r)  hdr_nxt = 1'b0;
      if (pos_eff == bcc_pkg::POS_VER   && b != ver_r)   hdr_nxt = 1'b0;
      crc_nxt = (pos_eff < CrcLoPos) ? bcc_pkg::crc8_step(crc_base, b) : crc_base;
      if (pos_eff == '0) begin
        rpt_nxt = '0;
      end
      if (pos_eff == bcc_pkg::POS_SEQ) begin
        seq_nxt = b;
      end else if (pos_eff == bcc_pkg::POS_FLAGS) begin
        flags_nxt = b;
      end else if (pos_eff >= bcc_pkg::POS_RPT && pos_eff < KeyPos) begin
        rpt_nxt[8*rpt_idx +: 8] = b;
      end else if (pos_eff == KeyPos) begin
        key_nxt = b;
      end else if (pos_eff == CrcLoPos) begin
        crc_lo_nxt = b;
      end
      pos_nxt = (pos_eff == LastPos) ? '0 : pos_eff + 1'b1;
    end
  end

  // Classified frame goes out on the last byte.
  assign rec_push       = accept && (pos_eff == LastPos);
  assign rec.hdr_ok     = hdr_r;
  assign rec.crc_ok     = ({b, crc_lo_r} == crc_r);
  assign rec.report     = rpt_r;
  assign rec.sequence_b = seq_r;
  assign rec.flags      = flags_r;
  assign rec.lead_key   = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= bcc_pkg::CRC_INIT;
      hdr_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  // Staged payload is rewritten every frame before it is read.
  always_ff @(posedge clk) begin
    rpt_r    <= rpt_nxt;
    seq_r    <= seq_nxt;
    flags_r  <= flags_nxt;
    key_r    <= key_nxt;
    crc_lo_r <= crc_lo_nxt;
  end

  // Conditions watched by the checks below.
  assign start_take = accept && in_data.frame_start;
  assign magic_miss = accept && (pos_eff == bcc_pkg::POS_MAGIC) && (b != magic_r);

  `BCC_ASSERT_NEXT(a_start_pos, start_take, pos_r == 4'd1, "start byte did not reach position one")
  `BCC_ASSERT_SAME(a_rec_room, rec_push, !rec_full, "frame record pushed into a full queue")
  `BCC_ASSERT_NEXT(a_magic_bad, magic_miss, !hdr_r, "bad magic not flagged")

endmodule

>>> sv/bcc_back.sv
// Back end: applies a classified frame to the kept fields and event counters
// and forms the result item. Depends on bcc_pkg and the assert header.
`include "bridge_frame_crc_checker_assert.svh"

module bcc_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bcc_pkg::rec_t rec,
  input  logic          rec_empty,
  output logic          rec_pop,
  output logic          res_push,
  output bcc_pkg::out_t res,
  input  logic          res_full
);

  logic [63:0]            rpt_r, rpt_nxt;
  logic [7:0]             seq_r, seq_nxt;
  logic [7:0]             flags_r, flags_nxt;
  logic [7:0]             key_r, key_nxt;
  logic [COUNT_WIDTH-1:0] good_r, good_nxt;
  logic [COUNT_WIDTH-1:0] crcf_r, crcf_nxt;
  logic [COUNT_WIDTH-1:0] hdrf_r, hdrf_nxt;
  bcc_pkg::status_t       status;
  logic [2:0]             cnt_moved;
  logic                   take_frame;

  assign rec_pop  = !rec_empty && !res_full;
  assign res_push = rec_pop;

  // Header mismatch wins over a CRC mismatch.
  always_comb begin
    rpt_nxt   = rpt_r;
    seq_nxt   = seq_r;
    flags_nxt = flags_r;
    key_nxt   = key_r;
    good_nxt  = good_r;
    crcf_nxt  = crcf_r;
    hdrf_nxt  = hdrf_r;
    if (!rec.hdr_ok) begin
      status = bcc_pkg::ST_HDR_BAD;
    end else if (!rec.crc_ok) begin
      status = bcc_pkg::ST_CRC_BAD;
    end else begin
      status = bcc_pkg::ST_VALID;
    end
    if (rec_pop) begin
      case (status)
        bcc_pkg::ST_HDR_BAD: hdrf_nxt = hdrf_r + 1'b1;
        bcc_pkg::ST_CRC_BAD: crcf_nxt = crcf_r + 1'b1;
        default: begin
          rpt_nxt   = rec.report;
          seq_nxt   = rec.sequence_b;
          flags_nxt = rec.flags;
          key_nxt   = rec.lead_key;
          good_nxt  = good_r + 1'b1;
        end
      endcase
    end
  end

  // Result carries the state after this frame's update.
  assign res.frame_status    = status;
  assign res.held_report     = rpt_nxt;
  assign res.held_sequence   = seq_nxt;
  assign res.held_flags      = flags_nxt;
  assign res.held_first_key  = key_nxt;
  assign res.good_frames     = 32'(good_nxt);
  assign res.crc_failures    = 32'(crcf_nxt);
  assign res.header_failures = 32'(hdrf_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpt_r   <= '0;
      seq_r   <= '0;
      flags_r <= '0;
      key_r   <= bcc_pkg::KEY_RST;
      good_r  <= '0;
      crcf_r  <= '0;
      hdrf_r  <= '0;
    end else begin
      rpt_r   <= rpt_nxt;
      seq_r   <= seq_nxt;
      flags_r <= flags_nxt;
      key_r   <= key_nxt;
      good_r  <= good_nxt;
      crcf_r  <= crcf_nxt;
      hdrf_r  <= hdrf_nxt;
    end
  end

  // Conditions watched by the checks below.
  assign cnt_moved  = {good_nxt != good_r, crcf_nxt != crcf_r, hdrf_nxt != hdrf_r};
  assign take_frame = rec_pop && rec.hdr_ok && rec.crc_ok;

  `BCC_ASSERT_SAME(a_one_count, rec_pop, $onehot(cnt_moved), "not exactly one counter moved")
  `BCC_ASSERT_SAME(a_idle_hold, !rec_pop, cnt_moved == 3'b000, "counter moved without a frame")
  `BCC_ASSERT_NEXT(a_key_latch, take_frame, key_r == $past(rec.lead_key), "valid frame lost its key")

endmodule

>>> sv/bridge_frame_crc_checker.sv
// Top level of the bridge frame checker: front end, record queue, back end
// and result queue. Depends on bcc_pkg, bcc_fifo, bcc_front and bcc_back.

// Takes one frame byte per cycle while in_full is low (magic, type, version,
// sequence, flags, REPORT_BYTES report bytes, first key, CRC low, CRC high)
// and, on the last byte of each frame, queues one result: status, the fields
// of the last valid frame and three wrapping event counters. The front end
// keeps one byte per cycle while not stalled, with an eight-bit unrolled
// CRC-16/CCITT step; the result passes through the registered record queue
// and then the registered result queue before out_empty falls. Two-entry
// queues sit between front and back end and at the result side, so in_full
// rises only when both queues are full because results are not being popped.
module bridge_frame_crc_checker #(
  parameter int unsigned REPORT_BYTES = 8,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_push,
  input  bcc_pkg::in_t                  in_data,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output bcc_pkg::out_t                 out_data
);

  localparam int unsigned RecW = $bits(bcc_pkg::rec_t);
  localparam int unsigned OutW = $bits(bcc_pkg::out_t);

  logic          rec_push, rec_full, rec_empty, rec_pop;
  bcc_pkg::rec_t rec_in, rec_out;
  logic          res_push, res_full;
  bcc_pkg::out_t res;

  // Byte intake and classification.
  bcc_front #(
    .REPORT_BYTES(REPORT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .rec_push (rec_push),
    .rec      (rec_in),
    .rec_full (rec_full)
  );

  // Queue of classified frames.
  bcc_fifo #(
    .WIDTH(RecW),
    .DEPTH(bcc_pkg::QUEUE_DEPTH)
  ) u_rec_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rec_push),
    .wdata(rec_in),
    .full (rec_full),
    .pop  (rec_pop),
    .rdata(rec_out),
    .empty(rec_empty)
  );

  // Kept fields and counters.
  bcc_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec      (rec_out),
    .rec_empty(rec_empty),
    .rec_pop  (rec_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue toward the consumer.
  bcc_fifo #(
    .WIDTH(OutW),
    .DEPTH(bcc_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (out_pop),
    .rdata(out_data),
    .empty(out_empty)
  );

endmodule

>>> test/tb_bridge_frame_crc_checker.sv
// Self-checking testbench for bridge_frame_crc_checker: streams frame bytes through the
// push/full port and checks every frame verdict against a transaction-level predictor.
// Depends on bcc_pkg and the bridge_frame_crc_checker RTL.
module tb_bridge_frame_crc_checker;
  timeunit 1ns;
  timeprecision 1ps;
  import bcc_pkg::*;

  // Frame layout for the default report size.
  localparam int unsigned RPT_LEN = 8;
  localparam int unsigned FRAME_LEN = 8 + RPT_LEN;
  localparam int unsigned KEY_AT = POS_RPT + RPT_LEN;
  localparam int unsigned CRC_LO_AT = KEY_AT + 1;
  localparam int unsigned LAST_AT = KEY_AT + 2;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic in_push = 1'b0;
  in_t in_data = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_t out_data;

  bridge_frame_crc_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // Predictor state: header registers, frame being assembled, last valid frame.
  logic [7:0] want_magic, want_type, want_version;
  int unsigned frame_pos;
  logic [15:0] crc_acc;
  bit hdr_match;
  logic [63:0] stage_report;
  logic [7:0] stage_seq, stage_flags, stage_key, crc_lo_rx;
  logic [63:0] last_report;
  logic [7:0] last_seq, last_flags, last_key;
  logic [31:0] good_cnt, crc_bad_cnt, hdr_bad_cnt;
  out_t expected_verdicts[$];

  bit typed_armed = 1'b0;
  out_t typed_verdict;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  // Directed frames; a typed verdict replaces the predicted one where it is given.
  typedef struct {
    logic st;
    logic [7:0] magic, ftype, ver, seq, flags;
    logic [63:0] report;
    logic [7:0] key;
    logic [15:0] crc_err;
    int unsigned cut;
    bit typed;
    out_t verdict;
  } frame_case_t;

  localparam int unsigned N_CASES = 13;
  frame_case_t cases [N_CASES] = '{
    // Bad magic right after reset.
    '{1'b1, 8'h00, TYPE_RST, VER_RST, 8'h00, 8'h00, 64'h0, 8'h00, 16'h0000, 16, 1'b1,
      '{ST_HDR_BAD, 64'h0, 8'h00, 8'h00, 8'hFF, 32'd0, 32'd0, 32'd1}},
    // Good header, CRC off by one bit.
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'h12, 8'h34, 64'h0807_0605_0403_0201, 8'h56,
      16'h0001, 16, 1'b1, '{ST_CRC_BAD, 64'h0, 8'h00, 8'h00, 8'hFF, 32'd0, 32'd1, 32'd1}},
    // Header and CRC both wrong counts as a header mismatch only.
    '{1'b1, MAGIC_RST, 8'hFF, VER_RST, 8'h00, 8'h00, 64'h0, 8'h00, 16'h8000, 16, 1'b1,
      '{ST_HDR_BAD, 64'h0, 8'h00, 8'h00, 8'hFF, 32'd0, 32'd1, 32'd2}},
    // Valid frame with all-ones payload and a zero first key.
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00,
      16'h0000, 16, 1'b1, '{ST_VALID, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'h00,
      32'd1, 32'd1, 32'd2}},
    // Bad version keeps the held fields.
    '{1'b1, MAGIC_RST, TYPE_RST, 8'h00, 8'h00, 8'h00, 64'h0, 8'h00, 16'h0000, 16, 1'b1,
      '{ST_HDR_BAD, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'h00, 32'd1, 32'd1, 32'd3}},
    // Partial frame, dropped by the next start flag.
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'h77, 8'h88, 64'h1111_2222_3333_4444, 8'h99,
      16'h0000, 7, 1'b0, '0},
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'h00, 8'h00, 64'h0, 8'hFF, 16'h0000, 16, 1'b1,
      '{ST_VALID, 64'h0, 8'h00, 8'h00, 8'hFF, 32'd2, 32'd1, 32'd3}},
    // Back to back without a start flag.
    '{1'b0, MAGIC_RST, TYPE_RST, VER_RST, 8'hA5, 8'h5A, 64'h0123_4567_89AB_CDEF, 8'h3C,
      16'h0000, 16, 1'b0, '0},
    // Cut just before the CRC high byte.
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'h01, 8'h02, 64'hDEAD_BEEF_0BAD_F00D, 8'h03,
      16'h0000, 15, 1'b0, '0},
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'hC3, 8'h81, 64'h8000_0000_0000_0001, 8'h7E,
      16'h0000, 16, 1'b0, '0},
    // A lone start byte.
    '{1'b1, 8'hFF, TYPE_RST, VER_RST, 8'h00, 8'h00, 64'h0, 8'h00, 16'h0000, 1, 1'b0, '0},
    '{1'b1, MAGIC_RST, TYPE_RST, VER_RST, 8'h44, 8'hBB, 64'h5555_AAAA_5555_AAAA, 8'h10,
      16'hFFFF, 16, 1'b0, '0},
    '{1'b0, MAGIC_RST, TYPE_RST, VER_RST, 8'h6E, 8'h91, 64'h7FFF_FFFF_FFFF_FFFE, 8'hEF,
      16'h0000, 16, 1'b0, '0}
  };

  // CRC-16/CCITT, one input bit at a time, MSB first.
  function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    int i;
    c = acc;
    for (i = 7; i >= 0; i--) begin
      if (c[15] ^ b[i]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void reset_predictor();
    want_magic = MAGIC_RST;
    want_type = TYPE_RST;
    want_version = VER_RST;
    frame_pos = 0;
    crc_acc = CRC_INIT;
    hdr_match = 1'b1;
    stage_report = '0;
    stage_seq = '0;
    stage_flags = '0;
    stage_key = '0;
    crc_lo_rx = '0;
    last_report = '0;
    last_seq = '0;
    last_flags = '0;
    last_key = KEY_RST;
    good_cnt = '0;
    crc_bad_cnt = '0;
    hdr_bad_cnt = '0;
  endfunction

  // Advances the predictor by one accepted byte; emits is set on the last frame byte.
  task automatic track_frame_byte(input logic [7:0] b, input logic st, output bit emits,
                                  output out_t verdict);
    logic [15:0] rx_crc;
    if (st) frame_pos = 0;
    if (frame_pos == 0) begin
      crc_acc = CRC_INIT;
      hdr_match = 1'b1;
      stage_report = '0;
      stage_seq = '0;
      stage_flags = '0;
      stage_key = '0;
    end
    if (frame_pos == POS_MAGIC && b != want_magic) hdr_match = 1'b0;
    if (frame_pos == POS_TYPE && b != want_type) hdr_match = 1'b0;
    if (frame_pos == POS_VER && b != want_version) hdr_match = 1'b0;
    if (frame_pos < CRC_LO_AT) crc_acc = ccitt_update(crc_acc, b);

    if (frame_pos == POS_SEQ) stage_seq = b;
    else if (frame_pos == POS_FLAGS) stage_flags = b;
    else if (frame_pos >= POS_RPT && frame_pos < KEY_AT)
      stage_report[8*(frame_pos-POS_RPT) +: 8] = b;
    else if (frame_pos == KEY_AT) stage_key = b;
    else if (frame_pos == CRC_LO_AT) crc_lo_rx = b;

    verdict = '0;
    emits = (frame_pos == LAST_AT);
    if (!emits) begin
      frame_pos = frame_pos + 1;
    end else begin
      frame_pos = 0;
      rx_crc = {b, crc_lo_rx};
      if (!hdr_match) begin
        hdr_bad_cnt = hdr_bad_cnt + 32'd1;
        verdict.frame_status = ST_HDR_BAD;
      end else if (rx_crc != crc_acc) begin
        crc_bad_cnt = crc_bad_cnt + 32'd1;
        verdict.frame_status = ST_CRC_BAD;
      end else begin
        last_report = stage_report;
        last_seq = stage_seq;
        last_flags = stage_flags;
        last_key = stage_key;
        good_cnt = good_cnt + 32'd1;
        verdict.frame_status = ST_VALID;
      end
      verdict.held_report = last_report;
      verdict.held_sequence = last_seq;
      verdict.held_flags = last_flags;
      verdict.held_first_key = last_key;
      verdict.good_frames = good_cnt;
      verdict.crc_failures = crc_bad_cnt;
      verdict.header_failures = hdr_bad_cnt;
    end
  endtask

  // One byte transfer: optional idle cycles, then hold push until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic st);
    bit emits;
    out_t verdict;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{data_byte: b, frame_start: st};
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    track_frame_byte(b, st, emits, verdict);
    if (emits) begin
      if (typed_armed) begin
        verdict = typed_verdict;
        typed_armed = 1'b0;
      end
      expected_verdicts.push_back(verdict);
    end
    bytes_sent = bytes_sent + 1;
  endtask

  // Sends the first cut bytes of a frame; the CRC bytes come from the running CRC.
  task automatic send_frame(input logic st, input logic [7:0] magic, input logic [7:0] ftype,
                            input logic [7:0] ver, input logic [7:0] seq,
                            input logic [7:0] flags, input logic [63:0] report,
                            input logic [7:0] key, input logic [15:0] crc_err,
                            input int unsigned cut);
    logic [15:0] sent_crc;
    logic [7:0] b;
    int unsigned k;
    sent_crc = '0;
    for (k = 0; k < cut && k < FRAME_LEN; k++) begin
      if (k == CRC_LO_AT) sent_crc = crc_acc ^ crc_err;
      if (k == POS_MAGIC) b = magic;
      else if (k == POS_TYPE) b = ftype;
      else if (k == POS_VER) b = ver;
      else if (k == POS_SEQ) b = seq;
      else if (k == POS_FLAGS) b = flags;
      else if (k < KEY_AT) b = report[8*(k-POS_RPT) +: 8];
      else if (k == KEY_AT) b = key;
      else if (k == CRC_LO_AT) b = sent_crc[7:0];
      else b = sent_crc[15:8];
      send_byte(b, (k == 0) ? st : 1'b0);
    end
  endtask

  // Mostly well-formed frames with random content, some cut short, some raw noise.
  task automatic random_traffic(input int unsigned byte_budget);
    int unsigned first, kind, k, n, bad_field;
    logic [7:0] hdr [3];
    logic [15:0] err;
    first = bytes_sent;
    while (bytes_sent - first < byte_budget) begin
      kind = $urandom_range(99);
      if (kind < 15) begin
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++)
          send_byte(8'($urandom), $urandom_range(9) == 0);
      end else begin
        hdr = '{want_magic, want_type, want_version};
        if ($urandom_range(4) == 0) begin
          bad_field = $urandom_range(2);
          hdr[bad_field] = hdr[bad_field] ^ 8'($urandom_range(1, 255));
        end
        err = ($urandom_range(4) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        send_frame((frame_pos != 0) ? 1'b1 : 1'($urandom_range(1)), hdr[0], hdr[1], hdr[2],
                   8'($urandom), 8'($urandom), {$urandom, $urandom}, 8'($urandom), err,
                   (kind < 30) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN);
      end
    end
    // Close on a clean frame so the next phase starts at a frame boundary.
    send_frame(1'b1, want_magic, want_type, want_version, 8'($urandom), 8'($urandom),
               {$urandom, $urandom}, 8'($urandom), 16'h0000, FRAME_LEN);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Header registers are written back to back while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_MAGIC: want_magic = val;
      CFG_TYPE: want_type = val;
      CFG_VERSION: want_version = val;
      default: ;
    endcase
  endtask

  task automatic set_header(input logic [7:0] magic, input logic [7:0] ftype,
                            input logic [7:0] ver);
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_TYPE, ftype);
    write_reg(CFG_VERSION, ver);
    write_reg(CFG_UNUSED, 8'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void flag_field(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  task automatic compare_verdict(input out_t want, input out_t got);
    flag_field("frame_status", want.frame_status, got.frame_status);
    flag_field("held_report", want.held_report, got.held_report);
    flag_field("held_sequence", want.held_sequence, got.held_sequence);
    flag_field("held_flags", want.held_flags, got.held_flags);
    flag_field("held_first_key", want.held_first_key, got.held_first_key);
    flag_field("good_frames", want.good_frames, got.good_frames);
    flag_field("crc_failures", want.crc_failures, got.crc_failures);
    flag_field("header_failures", want.header_failures, got.header_failures);
  endtask

  // Result side: random stalls, check on every pop transfer.
  always @(negedge clk) out_pop <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin : check_pop
    out_t head;
    if (rst_n && out_pop && out_empty === 1'b0) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict with no frame pending, got %h", $time, out_data);
        fail_count = fail_count + 1;
      end else begin
        head = expected_verdicts.pop_front();
        compare_verdict(head, out_data);
      end
    end
  end

  initial begin
    int unsigned i;
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames and a first random stretch, no idling, reset header values.
    for (i = 0; i < N_CASES; i++) begin
      typed_armed = cases[i].typed;
      typed_verdict = cases[i].verdict;
      send_frame(cases[i].st, cases[i].magic, cases[i].ftype, cases[i].ver, cases[i].seq,
                 cases[i].flags, cases[i].report, cases[i].key, cases[i].crc_err,
                 cases[i].cut);
    end
    random_traffic(150);
    wait_drained();

    // Sender mostly idle.
    set_header(8'hFF, 8'h00, 8'hFF);
    send_idle_pct = 88;
    random_traffic(130);
    wait_drained();

    // Receiver mostly stalled, with a full pause of the sender half way.
    set_header(8'h00, 8'hFF, 8'h00);
    send_idle_pct = 0;
    stall_pct = 88;
    random_traffic(65);
    wait_drained();
    random_traffic(65);
    wait_drained();

    // Light idling on both sides with random header values.
    set_header(8'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 8;
    stall_pct = 8;
    random_traffic(130);
    wait_drained();

    if (fail_count == 0 && expected_verdicts.size() == 0)
      $display("bridge_frame_crc_checker regression: pass");
    else
      $display("bridge_frame_crc_checker regression: fail");
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("bridge_frame_crc_checker regression: fail");
    $finish;
  end

endmodule
